[rtl/core/sbdw_pkg.sv]
// ----------------------------------------------------------------------------
// sbdw_pkg
// Shared types, codes and helpers for the serial bus DMA descriptor walker.
// ----------------------------------------------------------------------------
package sbdw_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW = $clog2(FifoDepth);
  localparam int unsigned FifoCntW = $clog2(FifoDepth + 1);
  localparam logic [7:0] MaxReplyWords = 8'd128;
  localparam logic [15:0] MaxCommands = 16'hFFFF;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [31:0] WordStep = 32'd4;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_MEMDATA = 2'd1,
    OP_REPLY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_MREAD  = 3'd0,
    KIND_MWRITE = 3'd1,
    KIND_PWRITE = 3'd2,
    KIND_PREAD  = 3'd3,
    KIND_DONE   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CMD   = 3'd1,
    PH_RPTR  = 3'd2,
    PH_TX    = 3'd3,
    PH_REPLY = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CFG_DMA_ENABLE     = 2'd0,
    CFG_TRIGGER_SELECT = 2'd1,
    CFG_START_ADDRESS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [31:0] word;
    logic [1:0]  port;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t make_res(kind_t kind, logic [31:0] address, logic [31:0] word,
                                    logic [1:0] port, logic last);
    res_t r;
    r.kind    = kind;
    r.address = address;
    r.word    = word;
    r.port    = port;
    r.last    = last;
    return r;
  endfunction

endpackage

[rtl/core/sbdw_ifs.sv]
// ----------------------------------------------------------------------------
// sbdw channel interfaces
// Valid/ready channels for input events, results and register writes.
// ----------------------------------------------------------------------------
interface sbdw_in_if;
  import sbdw_pkg::*;
  logic        valid;
  logic        ready;
  op_t         operation;
  logic [31:0] data;
  logic        more;
  modport source (output valid, output operation, output data, output more, input ready);
  modport sink (input valid, input operation, input data, input more, output ready);
endinterface

interface sbdw_out_if;
  import sbdw_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [31:0] address;
  logic [31:0] word;
  logic [1:0]  port;
  logic        last;
  modport source (output valid, output kind, output address, output word, output port,
                  output last, input ready);
  modport sink (input valid, input kind, input address, input word, input port,
                input last, output ready);
endinterface

interface sbdw_cfg_if;
  import sbdw_pkg::*;
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/core/serial_bus_dma_descriptor_walker_top.sv]
// The first result of an event passes the event register and then the result queue before it
// is offered on the result port.
// One event is taken per cycle while each event yields at most one result and the queue has
// room; the result port moves one transaction per cycle, so events that yield two results are
// taken more slowly. An event is processed only with two of the four result queue slots free.
// Reset: synchronous active-low rst_n clears the control registers, walk state and the result queue.
// ----------------------------------------------------------------------------
// serial_bus_dma_descriptor_walker_top
// Command list DMA walker for a four-port serial peripheral bus.
// ----------------------------------------------------------------------------
module serial_bus_dma_descriptor_walker_top (
  input  logic        clk,
  input  logic        rst_n,
  sbdw_in_if.sink     in_ch,
  sbdw_out_if.source  out_ch,
  sbdw_cfg_if.sink    cfg_ch
);
  import sbdw_pkg::*;

  push_t               push;
  logic [FifoCntW-1:0] fifo_count;

  sbdw_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .fifo_count (fifo_count),
    .push       (push)
  );

  sbdw_res_fifo u_res_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .count  (fifo_count),
    .out_ch (out_ch)
  );

endmodule

[rtl/core/sbdw_res_fifo.sv]
// ----------------------------------------------------------------------------
// sbdw_res_fifo
// Result queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module sbdw_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  sbdw_pkg::push_t   push,
  output logic [sbdw_pkg::FifoCntW-1:0] count,
  sbdw_out_if.source        out_ch
);
  import sbdw_pkg::*;

  res_t                mem_r [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FifoPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FifoCntW-1:0] cnt_r, cnt_nxt;
  logic                pop;
  logic [FifoPtrW-1:0] wr_ptr_p1;

  assign pop       = out_ch.valid && out_ch.ready;
  assign wr_ptr_p1 = wr_ptr_r + FifoPtrW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FifoPtrW'(push.count);
    rd_ptr_nxt = rd_ptr_r + FifoPtrW'(pop);
    cnt_nxt    = cnt_r + FifoCntW'(push.count) - FifoCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign count          = cnt_r;
  assign out_ch.valid   = (cnt_r != '0);
  assign out_ch.kind    = mem_r[rd_ptr_r].kind;
  assign out_ch.address = mem_r[rd_ptr_r].address;
  assign out_ch.word    = mem_r[rd_ptr_r].word;
  assign out_ch.port    = mem_r[rd_ptr_r].port;
  assign out_ch.last    = mem_r[rd_ptr_r].last;

endmodule

[rtl/core/sbdw_engine.sv]
// ----------------------------------------------------------------------------
// sbdw_engine
// Event register, control registers and the list walking state machine.
// ----------------------------------------------------------------------------
module sbdw_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  sbdw_in_if.sink                       in_ch,
  sbdw_cfg_if.sink                      cfg_ch,
  input  logic [sbdw_pkg::FifoCntW-1:0] fifo_count,
  output sbdw_pkg::push_t               push
);
  import sbdw_pkg::*;

  logic        in_vld_r;
  op_t         in_op_r;
  logic [31:0] in_data_r;
  logic        in_more_r;

  logic        dma_enable_r;
  logic        trigger_select_r;
  logic [31:0] start_address_r;

  phase_t      phase_r, phase_nxt;
  logic [31:0] list_ptr_r, list_ptr_nxt;
  logic [31:0] reply_ptr_r, reply_ptr_nxt;
  logic [8:0]  send_rem_r, send_rem_nxt;
  logic [7:0]  reply_cnt_r, reply_cnt_nxt;
  logic [1:0]  cur_port_r, cur_port_nxt;
  logic        final_cmd_r, final_cmd_nxt;
  logic [15:0] cmd_cnt_r, cmd_cnt_nxt;
  logic        repeat_r, repeat_nxt;

  logic        consume;
  logic        stop;
  push_t       push_c;

  assign consume      = in_vld_r && (fifo_count <= FifoCntW'(FifoDepth - 2));
  assign in_ch.ready  = !in_vld_r || consume;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    phase_nxt     = phase_r;
    list_ptr_nxt  = list_ptr_r;
    reply_ptr_nxt = reply_ptr_r;
    send_rem_nxt  = send_rem_r;
    reply_cnt_nxt = reply_cnt_r;
    cur_port_nxt  = cur_port_r;
    final_cmd_nxt = final_cmd_r;
    cmd_cnt_nxt   = cmd_cnt_r;
    repeat_nxt    = repeat_r;
    stop          = 1'b0;
    push_c.count  = 2'd0;
    push_c.r0     = '0;
    push_c.r1     = '0;
    case (in_op_r)
      OP_START: begin
        if (phase_r == PH_IDLE && dma_enable_r && !(trigger_select_r && repeat_r)) begin
          if (trigger_select_r) begin
            repeat_nxt = 1'b1;
          end
          list_ptr_nxt = start_address_r + WordStep;
          cmd_cnt_nxt  = '0;
          phase_nxt    = PH_CMD;
          push_c.count = 2'd1;
          push_c.r0    = make_res(KIND_MREAD, start_address_r, '0, '0, 1'b1);
        end
      end
      OP_CLEAR: begin
        if (in_data_r[0]) begin
          repeat_nxt = 1'b0;
        end
      end
      OP_MEMDATA: begin
        unique case (phase_r)
          PH_CMD: begin
            send_rem_nxt  = {1'b0, in_data_r[7:0]} + 9'd1;
            cur_port_nxt  = in_data_r[17:16];
            final_cmd_nxt = in_data_r[31];
            cmd_cnt_nxt   = cmd_cnt_r + 16'd1;
            phase_nxt     = PH_RPTR;
            list_ptr_nxt  = list_ptr_r + WordStep;
            push_c.count  = 2'd1;
            push_c.r0     = make_res(KIND_MREAD, list_ptr_r, '0, '0, 1'b1);
          end
          PH_RPTR: begin
            reply_ptr_nxt = in_data_r;
            phase_nxt     = PH_TX;
            list_ptr_nxt  = list_ptr_r + WordStep;
            push_c.count  = 2'd1;
            push_c.r0     = make_res(KIND_MREAD, list_ptr_r, '0, '0, 1'b1);
          end
          PH_TX: begin
            send_rem_nxt = send_rem_r - 9'd1;
            push_c.count = 2'd2;
            push_c.r0    = make_res(KIND_PWRITE, '0, in_data_r, cur_port_r, 1'b0);
            if (send_rem_nxt != 9'd0) begin
              list_ptr_nxt = list_ptr_r + WordStep;
              push_c.r1    = make_res(KIND_MREAD, list_ptr_r, '0, '0, 1'b1);
            end else begin
              reply_cnt_nxt = '0;
              phase_nxt     = PH_REPLY;
              push_c.r1     = make_res(KIND_PREAD, '0, '0, cur_port_r, 1'b1);
            end
          end
          default: begin
          end
        endcase
      end
      OP_REPLY: begin
        if (phase_r == PH_REPLY) begin
          reply_ptr_nxt = reply_ptr_r + WordStep;
          reply_cnt_nxt = reply_cnt_r + 8'd1;
          stop          = ((reply_cnt_r == '0) && (in_data_r == AllOnes)) || !in_more_r ||
                          (reply_cnt_nxt >= MaxReplyWords);
          push_c.count  = 2'd2;
          push_c.r0     = make_res(KIND_MWRITE, reply_ptr_r, in_data_r, '0, 1'b0);
          if (!stop) begin
            push_c.r1 = make_res(KIND_PREAD, '0, '0, cur_port_r, 1'b1);
          end else if (final_cmd_r || (cmd_cnt_r >= MaxCommands)) begin
            phase_nxt = PH_IDLE;
            push_c.r1 = make_res(KIND_DONE, '0, '0, '0, 1'b1);
          end else begin
            phase_nxt    = PH_CMD;
            list_ptr_nxt = list_ptr_r + WordStep;
            push_c.r1    = make_res(KIND_MREAD, list_ptr_r, '0, '0, 1'b1);
          end
        end
      end
      default: begin
      end
    endcase
    if (!consume) begin
      push_c.count = 2'd0;
    end
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_op_r   <= in_ch.operation;
      in_data_r <= in_ch.data;
      in_more_r <= in_ch.more;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r         <= 1'b0;
      dma_enable_r     <= 1'b0;
      trigger_select_r <= 1'b0;
      start_address_r  <= '0;
      phase_r          <= PH_IDLE;
      list_ptr_r       <= '0;
      reply_ptr_r      <= '0;
      send_rem_r       <= '0;
      reply_cnt_r      <= '0;
      cur_port_r       <= '0;
      final_cmd_r      <= 1'b0;
      cmd_cnt_r        <= '0;
      repeat_r         <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_DMA_ENABLE:     dma_enable_r     <= cfg_ch.wdata[0];
          CFG_TRIGGER_SELECT: trigger_select_r <= cfg_ch.wdata[0];
          CFG_START_ADDRESS:  start_address_r  <= cfg_ch.wdata;
          default: begin
          end
        endcase
      end
      if (consume) begin
        phase_r     <= phase_nxt;
        list_ptr_r  <= list_ptr_nxt;
        reply_ptr_r <= reply_ptr_nxt;
        send_rem_r  <= send_rem_nxt;
        reply_cnt_r <= reply_cnt_nxt;
        cur_port_r  <= cur_port_nxt;
        final_cmd_r <= final_cmd_nxt;
        cmd_cnt_r   <= cmd_cnt_nxt;
        repeat_r    <= repeat_nxt;
      end
    end
  end

endmodule

[sim/serial_bus_dma_descriptor_walker_top_tb.sv]
// ----------------------------------------------------------------------------
// serial_bus_dma_descriptor_walker_top_tb
// Drives command-list walks into the DMA walker with random gaps on both
// channels and checks every result transaction against an in-bench predictor.
// ----------------------------------------------------------------------------
module serial_bus_dma_descriptor_walker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbdw_pkg::*;

  typedef struct {
    op_t         op;
    logic [31:0] data;
    logic        more;
  } bus_event_t;

  logic clk;
  logic rst_n;

  sbdw_in_if  in_ch();
  sbdw_out_if out_ch();
  sbdw_cfg_if cfg_ch();

  serial_bus_dma_descriptor_walker_top uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  bus_event_t  pending_events[$];
  res_t        expected_results[$];
  int          error_count = 0;
  bit          in_taken = 0;

  int          send_gap = 0;
  int          send_calm = 0;
  int          stall_left = 0;
  int          recv_calm = 0;
  int          cycle_no = 0;

  logic        dma_en = 1'b0;
  logic        vblank_mode = 1'b0;
  logic [31:0] list_base = '0;

  phase_t      walk_phase = PH_IDLE;
  logic [31:0] fetch_addr = '0;
  logic [31:0] reply_addr = '0;
  logic [8:0]  tx_left = '0;
  logic [7:0]  reply_words = '0;
  logic [1:0]  cur_port = '0;
  logic        end_of_list = 1'b0;
  logic [15:0] cmds_done = '0;
  logic        repeat_armed = 1'b0;

  bit          plan_vblank = 0;
  bit          plan_busy_starts = 0;
  int          noise_pct = 6;
  int          gen_count = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void push_res(kind_t kind, logic [31:0] address, logic [31:0] word,
                                   logic [1:0] port, logic last);
    res_t r;
    r.kind    = kind;
    r.address = address;
    r.word    = word;
    r.port    = port;
    r.last    = last;
    expected_results.push_back(r);
  endfunction

  function automatic void push_fetch(logic last);
    push_res(KIND_MREAD, fetch_addr, '0, '0, last);
    fetch_addr += WordStep;
  endfunction

  function automatic void compute_bus_requests(op_t op, logic [31:0] data, logic more);
    logic first_word;
    logic stop;
    case (op)
      OP_START: begin
        if (walk_phase == PH_IDLE && dma_en && !(vblank_mode && repeat_armed)) begin
          if (vblank_mode) repeat_armed = 1'b1;
          fetch_addr = list_base;
          cmds_done  = '0;
          walk_phase = PH_CMD;
          push_fetch(1'b1);
        end
      end
      OP_CLEAR: begin
        if (data[0]) repeat_armed = 1'b0;
      end
      OP_MEMDATA: begin
        case (walk_phase)
          PH_CMD: begin
            tx_left     = {1'b0, data[7:0]} + 9'd1;
            cur_port    = data[17:16];
            end_of_list = data[31];
            cmds_done   = cmds_done + 16'd1;
            walk_phase  = PH_RPTR;
            push_fetch(1'b1);
          end
          PH_RPTR: begin
            reply_addr = data;
            walk_phase = PH_TX;
            push_fetch(1'b1);
          end
          PH_TX: begin
            push_res(KIND_PWRITE, '0, data, cur_port, 1'b0);
            tx_left = tx_left - 9'd1;
            if (tx_left != 9'd0) begin
              push_fetch(1'b1);
            end else begin
              reply_words = '0;
              walk_phase  = PH_REPLY;
              push_res(KIND_PREAD, '0, '0, cur_port, 1'b1);
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (walk_phase == PH_REPLY) begin
          first_word = (reply_words == 8'd0);
          push_res(KIND_MWRITE, reply_addr, data, '0, 1'b0);
          reply_addr  = reply_addr + WordStep;
          reply_words = reply_words + 8'd1;
          stop = (first_word && data == AllOnes) || !more || (reply_words >= MaxReplyWords);
          if (!stop) begin
            push_res(KIND_PREAD, '0, '0, cur_port, 1'b1);
          end else if (end_of_list || cmds_done >= MaxCommands) begin
            walk_phase = PH_IDLE;
            push_res(KIND_DONE, '0, '0, '0, 1'b1);
          end else begin
            walk_phase = PH_CMD;
            push_fetch(1'b1);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_result();
    res_t exp;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected transaction: kind=%0d address=%h word=%h port=%0d last=%b",
               $time, out_ch.kind, out_ch.address, out_ch.word, out_ch.port, out_ch.last);
      error_count++;
      return;
    end
    exp = expected_results.pop_front();
    if (out_ch.kind !== exp.kind) begin
      $display("%0t: kind mismatch: expected %0d, actual %0d", $time, exp.kind, out_ch.kind);
      error_count++;
    end
    if (out_ch.address !== exp.address) begin
      $display("%0t: address mismatch: expected %h, actual %h", $time, exp.address,
               out_ch.address);
      error_count++;
    end
    if (out_ch.word !== exp.word) begin
      $display("%0t: word mismatch: expected %h, actual %h", $time, exp.word, out_ch.word);
      error_count++;
    end
    if (out_ch.port !== exp.port) begin
      $display("%0t: port mismatch: expected %0d, actual %0d", $time, exp.port, out_ch.port);
      error_count++;
    end
    if (out_ch.last !== exp.last) begin
      $display("%0t: last mismatch: expected %b, actual %b", $time, exp.last, out_ch.last);
      error_count++;
    end
  endfunction

  function automatic int pick_pause(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      calm_left = $urandom_range(60, 150);
      return 0;
    end
    if (r < 700) return 0;
    if (r < 930) return $urandom_range(1, 3);
    if (r < 990) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic void queue_event(op_t op, logic [31:0] data, logic more);
    bus_event_t ev;
    ev.op   = op;
    ev.data = data;
    ev.more = more;
    pending_events.push_back(ev);
    gen_count++;
  endfunction

  function automatic void maybe_noise(phase_t plan);
    if ($urandom_range(0, 99) >= noise_pct) return;
    case ($urandom_range(0, 3))
      0: queue_event(OP_CLEAR, $urandom, 1'($urandom_range(0, 1)));
      1: begin
        if (plan_busy_starts && plan != PH_IDLE)
          queue_event(OP_START, $urandom, 1'($urandom_range(0, 1)));
      end
      2: begin
        if (plan == PH_REPLY || plan == PH_IDLE)
          queue_event(OP_MEMDATA, $urandom, 1'($urandom_range(0, 1)));
      end
      default: begin
        if (plan != PH_REPLY) queue_event(OP_REPLY, $urandom, 1'($urandom_range(0, 1)));
      end
    endcase
  endfunction

  function automatic void gen_walk(int n_cmds, bit big);
    int          len;
    int          k;
    int          r;
    logic [31:0] w;
    bit          big_now;
    bit          ones_first;
    if (plan_vblank) begin
      r = $urandom_range(0, 99);
      if (r < 70) queue_event(OP_CLEAR, $urandom | 32'd1, 1'($urandom_range(0, 1)));
      else if (r < 85) queue_event(OP_CLEAR, $urandom & ~32'd1, 1'($urandom_range(0, 1)));
    end
    queue_event(OP_START, $urandom, 1'($urandom_range(0, 1)));
    maybe_noise(PH_CMD);
    for (int c = 0; c < n_cmds; c++) begin
      big_now = big && (c == 0);
      r = $urandom_range(0, 99);
      if (big_now) len = 255;
      else if (r < 70) len = $urandom_range(0, 3);
      else if (r < 95) len = $urandom_range(4, 15);
      else len = $urandom_range(16, 40);
      w = $urandom;
      w[7:0] = 8'(len);
      w[31] = (c == n_cmds - 1);
      queue_event(OP_MEMDATA, w, 1'($urandom_range(0, 1)));
      maybe_noise(PH_RPTR);
      if ($urandom_range(0, 99) < 20) w = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      else w = $urandom;
      queue_event(OP_MEMDATA, w, 1'($urandom_range(0, 1)));
      maybe_noise(PH_TX);
      for (int t = 0; t <= len; t++) begin
        queue_event(OP_MEMDATA, $urandom, 1'($urandom_range(0, 1)));
        maybe_noise((t == len) ? PH_REPLY : PH_TX);
      end
      r = $urandom_range(0, 99);
      ones_first = !big_now && (r < 15);
      if (big_now) k = 128;
      else if (ones_first) k = 1;
      else if (r > 97) k = $urandom_range(20, 40);
      else k = $urandom_range(1, 6);
      for (int i = 0; i < k; i++) begin
        if (ones_first) begin
          queue_event(OP_REPLY, AllOnes, 1'($urandom_range(0, 1)));
        end else begin
          w = $urandom;
          if (i == 0 && w == AllOnes) w = '0;
          if (i > 0 && $urandom_range(0, 9) == 0) w = AllOnes;
          queue_event(OP_REPLY, w, (big_now || i < k - 1));
        end
        if (i < k - 1) maybe_noise(PH_REPLY);
      end
      maybe_noise((c == n_cmds - 1) ? PH_IDLE : PH_CMD);
    end
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (pending_events.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_DMA_ENABLE:     dma_en = value[0];
      CFG_TRIGGER_SELECT: vblank_mode = value[0];
      CFG_START_ADDRESS:  list_base = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(bit en, bit ts, logic [31:0] base, int target, bit big);
    wait_idle();
    write_reg(CFG_DMA_ENABLE, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, en});
    write_reg(CFG_TRIGGER_SELECT, {31'($urandom), ts});
    write_reg(CFG_START_ADDRESS, base);
    plan_vblank      = ts;
    plan_busy_starts = en && !ts;
    gen_count        = 0;
    if (big) gen_walk(2, 1'b1);
    while (gen_count < target) begin
      gen_walk($urandom_range(1, 4), 1'b0);
      maybe_noise(PH_IDLE);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_result();
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) compute_bus_requests(in_ch.operation, in_ch.data, in_ch.more);
    end else begin
      in_taken = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_taken) begin
        pending_events.delete(0);
        send_gap = pick_pause(send_calm);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        in_ch.valid     <= 1'b1;
        in_ch.operation <= pending_events[0].op;
        in_ch.data      <= pending_events[0].data;
        in_ch.more      <= pending_events[0].more;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      cycle_no++;
      if ((cycle_no % 1500) == 700) stall_left = 200;
      else if (stall_left == 0) stall_left = pick_pause(recv_calm);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_START;
    in_ch.data      = '0;
    in_ch.more      = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_DMA_ENABLE;
    cfg_ch.wdata    = '0;
    rst_n           = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_event(OP_START, '0, 1'b0);
    queue_event(OP_MEMDATA, AllOnes, 1'b1);
    queue_event(OP_REPLY, '0, 1'b1);
    queue_event(OP_CLEAR, '0, 1'b0);
    wait_idle();
    write_reg(CFG_DMA_ENABLE, 32'd1);
    write_reg(CFG_TRIGGER_SELECT, 32'd0);
    write_reg(CFG_START_ADDRESS, 32'hFFFF_FFF8);
    queue_event(OP_START, '0, 1'b0);
    queue_event(OP_START, AllOnes, 1'b1);
    queue_event(OP_MEMDATA, 32'h7FFC_FF00, 1'b0);
    queue_event(OP_MEMDATA, 32'hFFFF_FFFC, 1'b0);
    queue_event(OP_REPLY, 32'h1234_5678, 1'b1);
    queue_event(OP_MEMDATA, AllOnes, 1'b0);
    queue_event(OP_MEMDATA, '0, 1'b0);
    queue_event(OP_REPLY, AllOnes, 1'b1);
    queue_event(OP_MEMDATA, 32'h8003_0001, 1'b0);
    queue_event(OP_MEMDATA, '0, 1'b0);
    queue_event(OP_MEMDATA, '0, 1'b0);
    queue_event(OP_MEMDATA, AllOnes, 1'b1);
    queue_event(OP_REPLY, '0, 1'b1);
    queue_event(OP_REPLY, AllOnes, 1'b1);
    queue_event(OP_REPLY, 32'h1234_5678, 1'b0);
    wait_idle();
    write_reg(CFG_TRIGGER_SELECT, 32'd1);
    queue_event(OP_CLEAR, 32'd1, 1'b0);
    queue_event(OP_START, '0, 1'b0);
    queue_event(OP_MEMDATA, 32'h8002_0000, 1'b0);
    queue_event(OP_MEMDATA, 32'h0000_1000, 1'b0);
    queue_event(OP_MEMDATA, 32'hA5A5_5A5A, 1'b0);
    queue_event(OP_REPLY, 32'hAAAA_5555, 1'b0);
    queue_event(OP_START, '0, 1'b0);

    run_phase(1'b1, 1'b0, 32'h0000_0000, 230, 1'b0);
    run_phase(1'b1, 1'b0, 32'hFFFF_FFF4, 230, 1'b0);
    run_phase(1'b1, 1'b1, $urandom, 230, 1'b0);
    run_phase(1'b0, 1'b1, 32'hFFFF_FFFF, 60, 1'b0);
    run_phase(1'b1, 1'b0, $urandom, 420, 1'b1);
    run_phase(1'b1, 1'b1, $urandom, 230, 1'b0);

    wait_idle();
    repeat (20) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
